// ===== design/gelu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gelu_pkg;

  // sample format
  localparam int FRAC_BITS = 11;
  localparam int INT_BITS  = 4;
  localparam int WORD_W    = 1 + INT_BITS + FRAC_BITS;

  // |x| to Q16, and the magnitude at which the tail is dropped (8.0)
  localparam int U_SHIFT = 16 - FRAC_BITS;
  localparam logic [WORD_W-1:0] CUT_MAG = WORD_W'(8 << FRAC_BITS);

  // internal widths, all set by |x| < 8.0 in Q16
  localparam int U_W    = 19;
  localparam int U2_W   = 22;
  localparam int U3_W   = 25;
  localparam int U4_W   = 28;
  localparam int T1_W   = 41;
  localparam int T2_W   = 43;
  localparam int T3_W   = 38;
  localparam int T4_W   = 47;
  localparam int ACC_W  = 48;
  localparam int P_W    = 23;
  localparam int P2_W   = 30;
  localparam int P4_W   = 60;
  localparam int Q_W    = 32;
  localparam int PROD_W = WORD_W + Q_W;

  localparam int DIV_STEPS = Q_W;

  // polynomial coefficients in Q24
  localparam logic [21:0] COEF_C1 = 22'd3369788;
  localparam logic [20:0] COEF_C2 = 21'd1844756;
  localparam logic [12:0] COEF_C3 = 13'd6543;
  localparam logic [18:0] COEF_C4 = 19'd342708;

  // 1.0 in Q40
  localparam logic [ACC_W-1:0] POLY_ONE = ACC_W'(1) << 40;

  // upper part of the 2^63 dividend, below any divisor
  localparam logic [P4_W-1:0] DIV_REM0 = P4_W'(1) << (Q_W - 1);

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (Q_W - 1);

  typedef struct packed {
    logic signed [WORD_W-1:0] x_in;
    logic                     in_last;
  } sample_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] y_out;
    logic                     out_last;
  } result_t;

  // per-sample data that rides along the pipeline
  typedef struct packed {
    logic              neg;
    logic              cut;
    logic              last;
    logic [WORD_W-1:0] mag;
  } side_t;

endpackage

`default_nettype wire

// ===== design/gelu_poly.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gelu_poly (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [gelu_pkg::U_W-1:0]   in_u,
  input  gelu_pkg::side_t            in_side,
  output logic                       out_vld,
  output logic [gelu_pkg::P4_W-1:0]  out_p4,
  output gelu_pkg::side_t            out_side
);
  import gelu_pkg::*;

  // stage a: u^2, c1*u
  logic              a_vld;
  side_t             a_side;
  logic [U_W-1:0]    a_u;
  logic [U2_W-1:0]   a_u2;
  logic [T1_W-1:0]   a_t1;
  logic [2*U_W-1:0]  uu;

  // stage b: u^3, u^4, c2*u^2
  logic              b_vld;
  side_t             b_side;
  logic [U3_W-1:0]   b_u3;
  logic [U4_W-1:0]   b_u4;
  logic [T1_W-1:0]   b_t1;
  logic [T2_W-1:0]   b_t2;
  logic [U2_W+U_W-1:0] u2u;
  logic [2*U2_W-1:0] u2u2;

  // stage c: c3*u^3, c4*u^4, partial sum
  logic              c_vld;
  side_t             c_side;
  logic [T3_W-1:0]   c_t3;
  logic [T4_W-1:0]   c_t4;
  logic [ACC_W-1:0]  c_s12;

  // stage d: p
  logic              d_vld;
  side_t             d_side;
  logic [P_W-1:0]    d_p;
  logic [ACC_W-1:0]  acc;

  // stage e: p^2
  logic              e_vld;
  side_t             e_side;
  logic [P2_W-1:0]   e_p2;
  logic [2*P_W-1:0]  pp;

  // stage f: p^4
  logic              f_vld;
  side_t             f_side;
  logic [P4_W-1:0]   f_p4;

  assign uu   = (2*U_W)'(in_u) * (2*U_W)'(in_u);
  assign u2u  = (U2_W+U_W)'(a_u2) * (U2_W+U_W)'(a_u);
  assign u2u2 = (2*U2_W)'(a_u2) * (2*U2_W)'(a_u2);
  assign acc  = c_s12 + ACC_W'(c_t3) + ACC_W'(c_t4);
  assign pp   = (2*P_W)'(d_p) * (2*P_W)'(d_p);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= in_side;
      a_u    <= in_u;
      a_u2   <= uu[2*U_W-1:16];
      a_t1   <= T1_W'(COEF_C1) * T1_W'(in_u);

      b_side <= a_side;
      b_u3   <= u2u[U2_W+U_W-1:16];
      b_u4   <= u2u2[2*U2_W-1:16];
      b_t1   <= a_t1;
      b_t2   <= T2_W'(COEF_C2) * T2_W'(a_u2);

      c_side <= b_side;
      c_t3   <= T3_W'(COEF_C3) * T3_W'(b_u3);
      c_t4   <= T4_W'(COEF_C4) * T4_W'(b_u4);
      c_s12  <= POLY_ONE + ACC_W'(b_t1) + ACC_W'(b_t2);

      // p stays below 128.0, so the top accumulator bit is always clear
      d_side <= c_side;
      d_p    <= acc[P_W+23:24];

      e_side <= d_side;
      e_p2   <= pp[2*P_W-1:16];

      f_side <= e_side;
      f_p4   <= P4_W'(e_p2) * P4_W'(e_p2);
    end
  end

  assign out_vld  = f_vld;
  assign out_p4   = f_p4;
  assign out_side = f_side;

endmodule

`default_nettype wire

// ===== design/gelu_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 2^63 / den, one quotient bit per stage, msb first
module gelu_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [gelu_pkg::P4_W-1:0] in_den,
  input  gelu_pkg::side_t           in_side,
  output logic                      out_vld,
  output logic [gelu_pkg::Q_W-1:0]  out_quot,
  output gelu_pkg::side_t           out_side
);
  import gelu_pkg::*;

  logic            vld  [0:DIV_STEPS-1];
  logic [P4_W-1:0] rem  [0:DIV_STEPS-1];
  logic [P4_W-1:0] den  [0:DIV_STEPS-1];
  logic [Q_W-1:0]  quo  [0:DIV_STEPS-1];
  side_t           sd   [0:DIV_STEPS-1];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic            prev_vld;
    logic [P4_W-1:0] prev_rem;
    logic [P4_W-1:0] prev_den;
    logic [Q_W-1:0]  prev_quo;
    side_t           prev_sd;
    logic [P4_W:0]   shl;
    logic [P4_W+1:0] diff;
    logic            take;

    if (k == 0) begin : g_first
      assign prev_vld = in_vld;
      assign prev_rem = DIV_REM0;
      assign prev_den = in_den;
      assign prev_quo = '0;
      assign prev_sd  = in_side;
    end else begin : g_next
      assign prev_vld = vld[k-1];
      assign prev_rem = rem[k-1];
      assign prev_den = den[k-1];
      assign prev_quo = quo[k-1];
      assign prev_sd  = sd[k-1];
    end

    // the low dividend bits are all zero, so only a zero shifts in
    assign shl  = {prev_rem, 1'b0};
    assign diff = {1'b0, shl} - {2'b00, prev_den};
    assign take = !diff[P4_W+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? diff[P4_W-1:0] : shl[P4_W-1:0];
        den[k] <= prev_den;
        quo[k] <= {prev_quo[Q_W-2:0], take};
        sd[k]  <= prev_sd;
      end
    end
  end

  assign out_vld  = vld[DIV_STEPS-1];
  assign out_quot = quo[DIV_STEPS-1];
  assign out_side = sd[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== design/gelu_rational_erf_approx.sv =====
`timescale 1ns / 1ps
`default_nettype none

// GELU on signed Q4.11 samples, y = x * cdf(x), with the normal cdf taken from
// the rational erf fit 1 - 0.5/p^4 (p a quartic in |x|) and rounded to nearest.
// One sample per cycle enters and leaves unless stalled; most stages are in
// the 32-stage restoring divider that forms 0.5/p^4 one quotient bit per stage.
// For |x| >= 8.0 the tail is dropped, so y = x above zero and 0 below.
// The last flag rides with its sample. A stall on a valid result freezes
// the whole pipeline in place and is passed straight back as sample_stall.
module gelu_rational_erf_approx (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  gelu_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output gelu_pkg::result_t result
);
  import gelu_pkg::*;

  logic en;

  logic [WORD_W-1:0] raw;
  logic [WORD_W-1:0] mag;
  logic              neg;

  logic           s1_vld;
  side_t          s1_side;
  logic [U_W-1:0] s1_u;

  logic            pl_vld;
  logic [P4_W-1:0] pl_p4;
  side_t           pl_side;

  logic           dv_vld;
  logic [Q_W-1:0] dv_quot;
  side_t          dv_side;
  logic [Q_W-1:0] qsel;

  logic              pr_vld;
  logic [PROD_W-1:0] pr_prod;
  side_t             pr_side;

  logic [PROD_W-1:0] ysum;
  logic [WORD_W-1:0] ymag;
  logic [WORD_W-1:0] yval;

  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  // input stage: sign and magnitude, -32768 gives magnitude 32768
  assign raw = sample.x_in;
  assign neg = raw[WORD_W-1];
  assign mag = neg ? (WORD_W'(0) - raw) : raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.neg  <= neg;
      s1_side.cut  <= (mag >= CUT_MAG);
      s1_side.last <= sample.in_last;
      s1_side.mag  <= mag;
      s1_u         <= U_W'(mag) << U_SHIFT;
    end
  end

  gelu_poly u_poly (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s1_vld),
    .in_u     (s1_u),
    .in_side  (s1_side),
    .out_vld  (pl_vld),
    .out_p4   (pl_p4),
    .out_side (pl_side)
  );

  gelu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (pl_vld),
    .in_den   (pl_p4),
    .in_side  (pl_side),
    .out_vld  (dv_vld),
    .out_quot (dv_quot),
    .out_side (dv_side)
  );

  assign qsel = dv_side.cut ? '0 : dv_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      pr_vld       <= dv_vld;
      result_valid <= pr_vld;
    end
  end

  // positive side: mag * (1 - q) = mag - mag*q, never below zero
  // the result magnitude never exceeds the input one, so no clamp is needed
  assign ysum = pr_side.neg ? (pr_prod + ROUND_HALF)
                            : ({pr_side.mag, Q_W'(0)} - pr_prod + ROUND_HALF);
  assign ymag = ysum[PROD_W-1:Q_W];
  assign yval = pr_side.neg ? (WORD_W'(0) - ymag) : ymag;

  always_ff @(posedge clk) begin
    if (en) begin
      pr_prod         <= PROD_W'(dv_side.mag) * PROD_W'(qsel);
      pr_side         <= dv_side;
      result.y_out    <= yval;
      result.out_last <= pr_side.last;
    end
  end

endmodule

`default_nettype wire

// ===== tb/gelu_rational_erf_approx_tb.sv =====
`timescale 1ns / 1ps

module gelu_rational_erf_approx_tb;
  import gelu_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int CALM_ITEMS   = 150;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 60;

  localparam logic [63:0] C1_Q24 = 64'd3369788;
  localparam logic [63:0] C2_Q24 = 64'd1844756;
  localparam logic [63:0] C3_Q24 = 64'd6543;
  localparam logic [63:0] C4_Q24 = 64'd342708;

  typedef struct packed {
    logic [15:0] x;
    logic        last;
    logic        typed;
    logic [15:0] y;
  } row_t;

  localparam int N_ROWS = 23;

  // typed rows: zero, the extremes and |x| >= 8.0 where the tail is dropped
  row_t dir_rows [0:N_ROWS-1] = '{
    '{16'h0000, 1'b0, 1'b1, 16'h0000},
    '{16'h7FFF, 1'b1, 1'b1, 16'h7FFF},
    '{16'h8000, 1'b0, 1'b1, 16'h0000},
    '{16'h4000, 1'b1, 1'b1, 16'h4000},
    '{16'hC000, 1'b0, 1'b1, 16'h0000},
    '{16'h5555, 1'b1, 1'b1, 16'h5555},
    '{16'hAAAA, 1'b0, 1'b1, 16'h0000},
    '{16'h3FFF, 1'b0, 1'b0, 16'h0000},
    '{16'hC001, 1'b1, 1'b0, 16'h0000},
    '{16'h0001, 1'b0, 1'b0, 16'h0000},
    '{16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{16'h0800, 1'b0, 1'b0, 16'h0000},
    '{16'hF800, 1'b0, 1'b0, 16'h0000},
    '{16'h1000, 1'b1, 1'b0, 16'h0000},
    '{16'hF000, 1'b0, 1'b0, 16'h0000},
    '{16'h0400, 1'b0, 1'b0, 16'h0000},
    '{16'hFC00, 1'b1, 1'b0, 16'h0000},
    '{16'h2000, 1'b0, 1'b0, 16'h0000},
    '{16'hE000, 1'b0, 1'b0, 16'h0000},
    '{16'h0123, 1'b0, 1'b0, 16'h0000},
    '{16'hFEDC, 1'b1, 1'b0, 16'h0000},
    '{16'h3000, 1'b0, 1'b0, 16'h0000},
    '{16'hD000, 1'b1, 1'b0, 16'h0000}
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  sample_t sample = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  result_t due_results [$];
  int      errors = 0;
  int      samples_sent = 0;
  int      results_checked = 0;
  int      input_stall_cycles = 0;
  logic    calm = 1'b0;
  logic    long_hold_done = 1'b0;

  gelu_rational_erf_approx i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // x * cdf(x) with cdf from the quartic fit, all in unsigned fixed point
  function automatic logic [15:0] gelu_fixed(input logic [15:0] raw);
    logic        neg;
    logic [63:0] mag, u, u2, u3, u4, acc, p, p2, p4, tail, cdf, ymag;
    neg  = raw[15];
    mag  = neg ? (64'h10000 - {48'd0, raw}) : {48'd0, raw};
    tail = '0;
    if (mag < (64'd8 << FRAC_BITS)) begin
      u   = mag << (16 - FRAC_BITS);
      u2  = (u * u) >> 16;
      u3  = (u2 * u) >> 16;
      u4  = (u2 * u2) >> 16;
      acc = (64'd1 << 40) + C1_Q24 * u + C2_Q24 * u2 + C3_Q24 * u3 + C4_Q24 * u4;
      p   = acc >> 24;
      p2  = (p * p) >> 16;
      p4  = p2 * p2;
      if (p4 != 0) begin
        tail = (64'd1 << 63) / p4;
      end
    end
    cdf  = neg ? tail : ((64'd1 << 32) - tail);
    ymag = (mag * cdf + (64'd1 << 31)) >> 32;
    if (neg) begin
      if (ymag > 64'h8000) begin
        ymag = 64'h8000;
      end
      ymag = 64'h10000 - ymag;
    end else if (ymag > 64'h7FFF) begin
      ymag = 64'h7FFF;
    end
    return ymag[15:0];
  endfunction

  function automatic logic [15:0] pick_sample();
    logic [15:0] mag;
    logic [15:0] x;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: x = 16'($urandom);
      4, 5, 6: begin
        mag = 16'($urandom_range(0, 16'h3FFF));
        x   = $urandom_range(0, 1) ? -mag : mag;
      end
      7: begin
        mag = 16'($urandom_range(0, 511));
        x   = $urandom_range(0, 1) ? -mag : mag;
      end
      8: begin
        // around the 8.0 cut
        mag = 16'($urandom_range(16'h3FF0, 16'h4010));
        x   = $urandom_range(0, 1) ? -mag : mag;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: x = 16'h7FFF;
          1: x = 16'h8000;
          2: x = 16'h0000;
          3: x = 16'hFFFF;
          4: x = 16'h4000;
          default: x = 16'hC000;
        endcase
      end
    endcase
    return x;
  endfunction

  // append one expected beat
  task automatic note_due(input result_t r);
    due_results.insert(due_results.size(), r);
  endtask

  task automatic offer_beat(input logic [15:0] x, input logic l);
    @(negedge clk);
    sample_valid <= 1'b1;
    sample       <= '{x_in: x, in_last: l};
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic hold_input(input int n);
    @(negedge clk);
    sample_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // sender
  initial begin
    logic [15:0] x;
    logic        l;
    logic        quiet;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      offer_beat(dir_rows[i].x, dir_rows[i].last);
      if (dir_rows[i].typed) begin
        note_due('{y_out: dir_rows[i].y, out_last: dir_rows[i].last});
      end else begin
        note_due('{y_out: gelu_fixed(dir_rows[i].x), out_last: dir_rows[i].last});
      end
      if ($urandom_range(0, 3) == 0) begin
        hold_input($urandom_range(1, 11));
      end
    end

    quiet = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        quiet = ($urandom_range(0, 2) == 0);
      end
      if (i == RANDOM_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end
      if (i == 900) begin
        // let the pipe run dry before going on
        hold_input(1);
        while (due_results.size() != 0) @(posedge clk);
      end else if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
        hold_input($urandom_range(1, 11));
      end
      x = pick_sample();
      l = 1'($urandom);
      offer_beat(x, l);
      note_due('{y_out: gelu_fixed(x), out_last: l});
    end

    hold_input(1);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples sent (%0d directed), %0d results checked",
             samples_sent, N_ROWS, results_checked);
    $display("input held back for %0d cycles, including one long output stall",
             input_stall_cycles);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!calm && !long_hold_done && samples_sent >= 400) begin
        // long hold so the pipe fills and pushes back on the input
        long_hold_done = 1'b1;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        result_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && sample_valid && sample_stall) begin
      input_stall_cycles++;
    end
    if (!rst && result_valid && !result_stall) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat y_out=%h out_last=%b",
                 $time, result.y_out, result.out_last);
      end else begin
        want = due_results.pop_front();
        results_checked++;
        if (result.y_out !== want.y_out) begin
          errors++;
          $display("%0t: y_out mismatch, expected %h actual %h",
                   $time, want.y_out, result.y_out);
        end
        if (result.out_last !== want.out_last) begin
          errors++;
          $display("%0t: out_last mismatch, expected %b actual %b",
                   $time, want.out_last, result.out_last);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", due_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
